// ===== rtl/core/gsp_pkg.sv =====
// Shared types and constants for the gamepad serial poller.
package gsp_pkg;

   localparam int TICK_W   = 18;
   localparam int LEN_W    = 10;
   localparam int BUTTON_W = 12;
   localparam int CSR_IDX_W = 2;

   localparam int PULSE_COUNT_DEF = 16;
   localparam int BUTTON_COUNT    = 12;

   localparam logic [TICK_W-1:0] FRAME_WAIT_RST  = TICK_W'(135168);
   localparam logic [LEN_W-1:0]  LATCH_RST       = LEN_W'(97);
   localparam logic [LEN_W-1:0]  SETUP_RST       = LEN_W'(45);
   localparam logic [LEN_W-1:0]  HALF_PERIOD_RST = LEN_W'(45);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WAIT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP       = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = CSR_IDX_W'(3);

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_LATCH,
      PH_SETUP,
      PH_CLOCK
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] frame_wait;
      logic [LEN_W-1:0]  latch;
      logic [LEN_W-1:0]  setup;
      logic [LEN_W-1:0]  half_period;
   } cfg_type;

   typedef struct packed {
      logic                latch_level;
      logic                clock_level;
      logic [BUTTON_W-1:0] buttons;
      logic                buttons_updated;
   } result_type;

endpackage

// ===== rtl/core/gsp_sequencer.sv =====
// Frame sequencer: wait, latch, setup and clock phases with button sampling.
module gsp_sequencer import gsp_pkg::*; #(
   parameter int PULSE_COUNT = PULSE_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       serial_data,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int PULSE_W = (PULSE_COUNT > 1) ? $clog2(PULSE_COUNT) : 1;

   phase_type             state_ff, state_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [PULSE_W-1:0]    pulse_ff, pulse_in;
   logic                  high_ff, high_in;
   logic [BUTTON_W-1:0]   shift_ff, shift_in;
   logic [BUTTON_W-1:0]   word_ff, word_in;

   logic [TICK_W-1:0]     length;
   logic [TICK_W-1:0]     limit;
   logic                  seg_end;
   logic                  last_pulse;
   logic                  publish;

   always_comb begin
      unique case (state_ff)
         PH_WAIT:  length = cfg.frame_wait;
         PH_LATCH: length = TICK_W'(cfg.latch);
         PH_SETUP: length = TICK_W'(cfg.setup);
         PH_CLOCK: length = TICK_W'(cfg.half_period);
         default:  length = cfg.frame_wait;
      endcase
   end

   // treat a zero length as one tick
   assign limit      = (length == '0) ? TICK_W'(1) : length;
   assign seg_end    = ({1'b0, tick_ff} + (TICK_W+1)'(1)) >= {1'b0, limit};
   assign last_pulse = (32'(pulse_ff) == PULSE_COUNT - 1);
   assign publish    = (state_ff == PH_CLOCK) && seg_end && high_ff && last_pulse;

   // next state
   always_comb begin
      state_in = state_ff;
      tick_in  = seg_end ? '0 : tick_ff + TICK_W'(1);
      pulse_in = pulse_ff;
      high_in  = high_ff;
      if (seg_end) begin
         unique case (state_ff)
            PH_WAIT:  state_in = PH_LATCH;
            PH_LATCH: state_in = PH_SETUP;
            PH_SETUP: begin
               state_in = PH_CLOCK;
               pulse_in = '0;
               high_in  = 1'b0;
            end
            PH_CLOCK: begin
               if (!high_ff) begin
                  high_in = 1'b1;
               end else begin
                  high_in = 1'b0;
                  if (last_pulse) begin
                     pulse_in = '0;
                     state_in = PH_WAIT;
                  end else begin
                     pulse_in = pulse_ff + PULSE_W'(1);
                  end
               end
            end
            default: state_in = PH_WAIT;
         endcase
      end
   end

   // outputs and sample word
   always_comb begin
      shift_in = shift_ff;
      word_in  = word_ff;
      result.latch_level = (state_ff == PH_LATCH);
      result.clock_level = (state_ff == PH_CLOCK) ? high_ff : 1'b1;
      // sample on the falling edge: first tick of the low half
      if (state_ff == PH_CLOCK && !high_ff && tick_ff == '0) begin
         for (int i = 0; i < BUTTON_W; i++) begin
            if (i < BUTTON_COUNT && 32'(pulse_ff) == i) begin
               shift_in[i] = ~serial_data;
            end
         end
      end
      if (state_ff == PH_SETUP && seg_end) begin
         shift_in = '0;
      end
      if (publish) begin
         word_in = shift_in;
      end
      result.buttons         = word_in;
      result.buttons_updated = publish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_WAIT;
         tick_ff  <= '0;
         pulse_ff <= '0;
         high_ff  <= 1'b0;
         shift_ff <= '0;
         word_ff  <= '0;
      end else if (step) begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         pulse_ff <= pulse_in;
         high_ff  <= high_in;
         shift_ff <= shift_in;
         word_ff  <= word_in;
      end
   end

`ifndef SYNTH
   a_pulse_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != PH_CLOCK) |-> (pulse_ff == '0))
      else $error("pulse index left non-zero outside clocking");

   a_word_on_publish: assert property (@(posedge clock) disable iff (reset)
      !$stable(word_ff) |-> $past(publish && step))
      else $error("button word changed without a publish");
`endif

endmodule

// ===== rtl/core/gamepad_serial_poller_top.sv =====
// Top level of the gamepad serial poller: handshakes, registers and result stage.
//
// Polls a shift-register gamepad. Every input transaction is one tick of the
// timing base and carries the sampled serial data pin; every input transaction
// produces exactly one result transaction holding the latch and clock levels
// for that tick, the last published button word and a flag that marks the tick
// on which a new word is published. A frame idles for frame_wait_ticks, holds
// the latch high for latch_ticks, waits setup_ticks, then gives PULSE_COUNT
// clock pulses (half_period_ticks low, then half_period_ticks high; the clock
// idles high). The inverted data line is sampled on each falling edge for the
// first twelve pulses, and all twelve buttons publish together on the last
// tick of the last pulse. A zero length behaves as one tick. One transaction
// is taken every clock cycle: the sequencer state and the result register are
// updated in the same cycle, and req_stall rises only while a finished result
// is held by rsp_stall. Registers take effect at once; write them while idle.
module gamepad_serial_poller_top import gsp_pkg::*; #(
   parameter int PULSE_COUNT = PULSE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input transactions
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_serial_data,
   // result transactions
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_latch_level,
   output logic                  rsp_clock_level,
   output logic [BUTTON_W-1:0]   rsp_buttons,
   output logic                  rsp_buttons_updated,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TICK_W-1:0]     csr_data
);

   cfg_type    cfg_ff, cfg_in;
   result_type result;
   result_type out_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WAIT:  cfg_in.frame_wait  = csr_data;
            CSR_LATCH:       cfg_in.latch       = csr_data[LEN_W-1:0];
            CSR_SETUP:       cfg_in.setup       = csr_data[LEN_W-1:0];
            CSR_HALF_PERIOD: cfg_in.half_period = csr_data[LEN_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_wait  <= FRAME_WAIT_RST;
         cfg_ff.latch       <= LATCH_RST;
         cfg_ff.setup       <= SETUP_RST;
         cfg_ff.half_period <= HALF_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stall only when the held result is itself stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   gsp_sequencer #(
      .PULSE_COUNT (PULSE_COUNT)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .serial_data (req_serial_data),
      .cfg         (cfg_ff),
      .result      (result)
   );

   // result register: load on accept, drop once taken, hold while stalled
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_latch_level     = out_ff.latch_level;
   assign rsp_clock_level     = out_ff.clock_level;
   assign rsp_buttons         = out_ff.buttons;
   assign rsp_buttons_updated = out_ff.buttons_updated;

`ifndef SYNTH
   a_latch_clock_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_latch_level) |-> rsp_clock_level)
      else $error("clock low while latch high");

   a_publish_clock_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_buttons_updated) |-> (rsp_clock_level && !rsp_latch_level))
      else $error("publish outside the high half of a pulse");

   a_buttons_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && !$stable(rsp_buttons)) |-> rsp_buttons_updated)
      else $error("button word changed without an update flag");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the gamepad serial poller top level.
`timescale 1ns / 1ps

module tb import gsp_pkg::*; ();

   // Cycles with no transaction on any channel before the run is declared hung.
   localparam int QUIET_LIMIT = 4000;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PULSES = PULSE_COUNT_DEF;
   localparam logic [TICK_W-1:0] FRAME_WAIT_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // Result of any tick outside the latch and clock segments, nothing published yet.
   localparam result_type PAD_IDLE = '{1'b0, 1'b1, '0, 1'b0};

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum int {PADS_RANDOM, PADS_PRESSED, PADS_RELEASED} pad_mode_type;

   // One row of the directed table: the pin level for the tick, whether the
   // expected result is written out here, and whether to drop every length
   // register to zero (one tick each) before the tick.
   typedef struct packed {
      logic       data;
      logic       typed;
      result_type want;
      logic       zero_lengths;
   } tick_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_serial_data = 1'b1;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_latch_level;
   logic                 rsp_clock_level;
   logic [BUTTON_W-1:0]  rsp_buttons;
   logic                 rsp_buttons_updated;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FRAME_WAIT;
   logic [TICK_W-1:0]    csr_data = '0;

   // Own copy of the poller: lengths and sequencer state.
   cfg_type               pad_cfg;
   phase_type             pad_phase;
   logic [TICK_W-1:0]     pad_ticks;
   logic [4:0]            pad_pulse;
   logic                  pad_high_half;
   logic [BUTTON_W-1:0]   pad_shift;
   logic [BUTTON_W-1:0]   pad_word;

   result_type pad_results_due [$];

   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int ticks_sent = 0;
   int results_seen = 0;
   int words_published = 0;
   int settings_loaded = 0;

   // Directed table. The first rows run on the reset lengths, deep inside the
   // frame wait, so the result can be written out by hand. Then every length
   // drops to zero while the wait count is already past it: the wait ends on
   // the very next tick, and the rest walk latch, setup and the first pulses.
   tick_row_type poll_table [25] = '{
      '{1'b0, 1'b1, PAD_IDLE, 1'b0},
      '{1'b1, 1'b1, PAD_IDLE, 1'b0},
      '{1'b0, 1'b1, PAD_IDLE, 1'b0},
      '{1'b1, 1'b1, PAD_IDLE, 1'b0},
      '{1'b1, 1'b1, PAD_IDLE, 1'b0},
      '{1'b0, 1'b1, PAD_IDLE, 1'b0},
      '{1'b0, 1'b0, '0, 1'b1},
      '{1'b1, 1'b0, '0, 1'b0},
      '{1'b0, 1'b0, '0, 1'b0},
      '{1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 1'b0, '0, 1'b0},
      '{1'b1, 1'b0, '0, 1'b0},
      '{1'b0, 1'b0, '0, 1'b0},
      '{1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 1'b0, '0, 1'b0},
      '{1'b1, 1'b0, '0, 1'b0},
      '{1'b1, 1'b0, '0, 1'b0},
      '{1'b0, 1'b0, '0, 1'b0},
      '{1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 1'b0, '0, 1'b0},
      '{1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 1'b0, '0, 1'b0},
      '{1'b1, 1'b0, '0, 1'b0},
      '{1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 1'b0, '0, 1'b0}
   };

   gamepad_serial_poller_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_serial_data     (req_serial_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_latch_level     (rsp_latch_level),
      .rsp_clock_level     (rsp_clock_level),
      .rsp_buttons         (rsp_buttons),
      .rsp_buttons_updated (rsp_buttons_updated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #6 clock = ~clock;

   // Advance the poller by one tick and return the levels it shows on that tick.
   function automatic result_type poll_tick(input logic data);
      result_type        r;
      logic [TICK_W-1:0] seg_len;
      r = PAD_IDLE;
      r.buttons = pad_word;
      case (pad_phase)
         PH_WAIT: seg_len = pad_cfg.frame_wait;
         PH_LATCH: begin
            seg_len = TICK_W'(pad_cfg.latch);
            r.latch_level = 1'b1;
         end
         PH_SETUP: seg_len = TICK_W'(pad_cfg.setup);
         default: begin
            seg_len = TICK_W'(pad_cfg.half_period);
            r.clock_level = pad_high_half;
            // Falling edge: store the inverted pin, drop buttons past the word.
            if (!pad_high_half && pad_ticks == '0 && 32'(pad_pulse) < BUTTON_COUNT)
               pad_shift[pad_pulse] = ~data;
         end
      endcase
      // A zero length lasts one tick.
      if (seg_len == '0)
         seg_len = TICK_W'(1);
      // A length lowered below the running count ends the segment now.
      if (32'(pad_ticks) + 1 < 32'(seg_len)) begin
         pad_ticks = pad_ticks + 1'b1;
      end else begin
         pad_ticks = '0;
         case (pad_phase)
            PH_WAIT: pad_phase = PH_LATCH;
            PH_LATCH: pad_phase = PH_SETUP;
            PH_SETUP: begin
               pad_phase = PH_CLOCK;
               pad_pulse = '0;
               pad_high_half = 1'b0;
               pad_shift = '0;
            end
            default: begin
               if (!pad_high_half) begin
                  pad_high_half = 1'b1;
               end else begin
                  pad_high_half = 1'b0;
                  if (32'(pad_pulse) + 1 >= PULSES) begin
                     pad_word = pad_shift;
                     r.buttons = pad_word;
                     r.buttons_updated = 1'b1;
                     pad_pulse = '0;
                     pad_phase = PH_WAIT;
                  end else begin
                     pad_pulse = pad_pulse + 1'b1;
                  end
               end
            end
         endcase
      end
      return r;
   endfunction

   // Offer one tick after any idle gap; predict it once it is taken.
   task automatic offer_tick(input logic data, input logic typed, input result_type want);
      result_type due;
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_serial_data <= data;
      do @(posedge clock); while (req_stall);
      due = poll_tick(data);
      pad_results_due.push_back(typed ? want : due);
      ticks_sent++;
   endtask

   // Stop offering and hold until every outstanding result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pad_results_due.size() != 0)
         @(posedge clock);
   endtask

   // Write all four length registers back to back; the narrow ones get random
   // upper bits, which the block must ignore.
   task automatic load_lengths(input cfg_type c);
      logic [CSR_IDX_W-1:0] idx;
      logic [TICK_W-1:0]    value;
      int                   k;
      for (k = 0; k < 4; k++) begin
         idx = CSR_IDX_W'(k);
         case (idx)
            CSR_FRAME_WAIT: value = c.frame_wait;
            CSR_LATCH:      value = {(TICK_W-LEN_W)'($urandom), c.latch};
            CSR_SETUP:      value = {(TICK_W-LEN_W)'($urandom), c.setup};
            default:        value = {(TICK_W-LEN_W)'($urandom), c.half_period};
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= value;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      pad_cfg = c;
      settings_loaded++;
   endtask

   // One phase: settle, load lengths, then stream ticks under one idle pattern.
   task automatic run_phase(input cfg_type c, input int count, input idle_mode_type idling,
                            input pad_mode_type pads, input bit hold_off, input bit mid_drain);
      int   k;
      logic data;
      drain_results();
      // Let the block settle so nothing is in flight when the lengths change.
      repeat (2) @(posedge clock);
      load_lengths(c);
      send_gap_pct = (idling == IDLE_SEND) ? 85 : (idling == IDLE_BOTH) ? 32 : 0;
      recv_stall_pct = (idling == IDLE_RECV) ? 85 : (idling == IDLE_BOTH) ? 32 : 0;
      if (hold_off)
         holds_asked++;
      for (k = 0; k < count; k++) begin
         if (mid_drain && k == count / 2)
            drain_results();
         case (pads)
            PADS_PRESSED:  data = 1'b0;
            PADS_RELEASED: data = 1'b1;
            default:       data = 1'($urandom);
         endcase
         offer_tick(data, 1'b0, '0);
      end
   endtask

   // Compare one result transaction with the oldest prediction.
   task automatic check_result();
      result_type want;
      results_seen++;
      if (rsp_buttons_updated)
         words_published++;
      if (pad_results_due.size() == 0) begin
         $display("%0t: result with nothing outstanding", $time);
         mismatches++;
      end else begin
         want = pad_results_due.pop_front();
         if (rsp_latch_level !== want.latch_level) begin
            $display("%0t: latch_level expected %b got %b", $time,
                     want.latch_level, rsp_latch_level);
            mismatches++;
         end
         if (rsp_clock_level !== want.clock_level) begin
            $display("%0t: clock_level expected %b got %b", $time,
                     want.clock_level, rsp_clock_level);
            mismatches++;
         end
         if (rsp_buttons !== want.buttons) begin
            $display("%0t: buttons expected %h got %h", $time, want.buttons, rsp_buttons);
            mismatches++;
         end
         if (rsp_buttons_updated !== want.buttons_updated) begin
            $display("%0t: buttons_updated expected %b got %b", $time,
                     want.buttons_updated, rsp_buttons_updated);
            mismatches++;
         end
      end
   endtask

   // Result side: check each accepted transaction, then pick next cycle's stall.
   // A requested hold-off keeps stall high for a fixed stretch, counted here,
   // while the sender keeps offering so the block fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
         end
      end
   end

   // Watchdog: any transaction on any channel resets the quiet count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                  quiet_cycles, pad_results_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cfg_type c;
      int      n;
      int      pick;
      // Reset state of the block, lengths included.
      pad_cfg = '{FRAME_WAIT_RST, LATCH_RST, SETUP_RST, HALF_PERIOD_RST};
      pad_phase = PH_WAIT;
      pad_ticks = '0;
      pad_pulse = '0;
      pad_high_half = 1'b0;
      pad_shift = '0;
      pad_word = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: walk the table.
      foreach (poll_table[i]) begin
         if (poll_table[i].zero_lengths) begin
            drain_results();
            load_lengths('0);
         end
         offer_tick(poll_table[i].data, poll_table[i].typed, poll_table[i].want);
      end

      // Zero lengths throughout: shortest possible frames, no idling.
      run_phase('0, 150, IDLE_NONE, PADS_RANDOM, 1'b0, 1'b0);
      // Every length at its maximum: stretch whatever segment is running.
      run_phase('{FRAME_WAIT_MAX, LEN_MAX, LEN_MAX, LEN_MAX}, 40, IDLE_BOTH,
                PADS_RANDOM, 1'b0, 1'b0);
      // Short lengths again: the stretched segment ends at once. Pause halfway
      // until every result is back.
      run_phase('{TICK_W'(3), LEN_W'(2), LEN_W'(2), LEN_W'(1)}, 200, IDLE_SEND,
                PADS_PRESSED, 1'b0, 1'b1);
      // Long receiver hold-off while the sender keeps offering.
      run_phase('{TICK_W'(2), LEN_W'(1), LEN_W'(1), LEN_W'(1)}, 150, IDLE_NONE,
                PADS_RELEASED, 1'b1, 1'b0);

      // Random part: short frames mostly, now and then one length at its top.
      for (int p = 0; p < 12; p++) begin
         c = '{TICK_W'($urandom_range(0, 6)), LEN_W'($urandom_range(0, 3)),
               LEN_W'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 3))};
         n = $urandom_range(100, 160);
         if (p % 4 == 3) begin
            pick = $urandom_range(0, 3);
            case (CSR_IDX_W'(pick))
               CSR_FRAME_WAIT: c.frame_wait = FRAME_WAIT_MAX;
               CSR_LATCH:      c.latch = LEN_MAX;
               CSR_SETUP:      c.setup = LEN_MAX;
               default:        c.half_period = LEN_MAX;
            endcase
            n = 60;
         end
         run_phase(c, n, idle_mode_type'(p % 4), pad_mode_type'(p % 3), 1'b0, 1'b0);
      end

      drain_results();
      // Let anything unexpected surface before the verdict.
      repeat (8) @(posedge clock);
      $display("run covered %0d ticks under %0d length settings and four idle patterns",
               ticks_sent, settings_loaded);
      $display("%0d results checked, %0d button words published, %0d mismatches",
               results_seen, words_published, mismatches);
      if (mismatches == 0 && pad_results_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
